// ----- src/alhf_pkg.sv -----
`default_nettype none
package alhf_pkg;

    // Result status codes
    localparam logic [2:0] STAT_NONE  = 3'd0;
    localparam logic [2:0] STAT_LOLO  = 3'd1;
    localparam logic [2:0] STAT_LOW   = 3'd2;
    localparam logic [2:0] STAT_HIGH  = 3'd3;
    localparam logic [2:0] STAT_HIHI  = 3'd4;
    localparam logic [2:0] STAT_UNDEF = 3'd5;

    // Range codes
    localparam logic [2:0] RNG_LOLO = 3'd1;
    localparam logic [2:0] RNG_LOW  = 3'd2;
    localparam logic [2:0] RNG_NORM = 3'd3;
    localparam logic [2:0] RNG_HIGH = 3'd4;
    localparam logic [2:0] RNG_HIHI = 3'd5;

    // Register indexes
    localparam logic [2:0] REG_HIHI = 3'd0;
    localparam logic [2:0] REG_HIGH = 3'd1;
    localparam logic [2:0] REG_LOW  = 3'd2;
    localparam logic [2:0] REG_LOLO = 3'd3;
    localparam logic [2:0] REG_HYST = 3'd4;
    localparam logic [2:0] REG_SEVR = 3'd5;
    localparam logic [2:0] REG_FTIM = 3'd6;
    localparam logic [2:0] REG_USEV = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASS,
        ST_DIV,
        ST_MUL,
        ST_FIN,
        ST_OUT
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;      // capture input request
        logic classify;  // limit check, pick path
        logic div_start; // begin alpha division
        logic div_step;  // one quotient bit
        logic mul_step;  // one multiply phase
        logic finish;    // compute range, update state
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic need_filter; // divide/multiply path needed
        logic div_done;
        logic mul_done;
    } sts_t;

endpackage
`default_nettype wire

// ----- src/alhf_ctrl.sv -----
`default_nettype none
module alhf_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output alhf_pkg::cmd_t       cmd,
    input  wire alhf_pkg::sts_t  sts
);
    import alhf_pkg::*;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) state_next = ST_CLASS;
            end
            ST_CLASS: state_next = sts.need_filter ? ST_DIV : ST_FIN;
            ST_DIV:
            begin
                if (sts.div_done) state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (sts.mul_done) state_next = ST_FIN;
            end
            ST_FIN: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CLASS:
            begin
                cmd.classify = 1'b1;
                cmd.div_start = sts.need_filter;
            end
            ST_DIV: cmd.div_step = 1'b1;
            ST_MUL: cmd.mul_step = 1'b1;
            ST_FIN: cmd.finish = 1'b1;
            ST_OUT: out_valid = 1'b1;
            default: ;
        endcase
    end

    // Output request is held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");
    a_div_after_class: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> state_reg == ST_DIV)
        else $error("division not entered");
endmodule
`default_nettype wire

// ----- src/alhf_dp.sv -----
`default_nettype none
module alhf_dp
#(
    parameter int FRAC = 24
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire alhf_pkg::cmd_t     cmd,
    output alhf_pkg::sts_t          sts,
    input  wire logic signed [31:0] sample,
    input  wire logic               undefined,
    input  wire logic [31:0]        elapsed_ms,
    input  wire logic [1:0]         prior_severity,
    input  wire logic signed [31:0] limit_hihi,
    input  wire logic signed [31:0] limit_high,
    input  wire logic signed [31:0] limit_low,
    input  wire logic signed [31:0] limit_lolo,
    input  wire logic [30:0]        hysteresis,
    input  wire logic [7:0]         limit_severities,
    input  wire logic [23:0]        filter_time_ms,
    input  wire logic [1:0]         undefined_severity,
    output logic [2:0]              alarm_status,
    output logic [1:0]              alarm_severity,
    output logic                    status_taken,
    output logic [2:0]              filtered_range
);
    import alhf_pkg::*;

    localparam int NUMW = 24 + FRAC;         // dividend width
    localparam int DENW = 33;
    localparam int QW = FRAC + 1;            // alpha fits in FRAC+1 bits
    localparam int CW = $clog2(NUMW + 1);
    localparam logic [FRAC-1:0] THRESH =
        FRAC'(((64'd6321 << FRAC) + 64'd5000) / 64'd10000);
    localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC;

    // Captured request
    logic signed [31:0] val_reg;
    logic               undef_reg;
    logic [31:0]        elap_reg;
    logic [1:0]         prior_reg;
    // Persistent state
    logic [31:0]        lalm_reg, lalm_next;
    logic signed [31:0] flvl_reg, flvl_next;
    // Classification
    logic [2:0]         crange_reg;
    logic [1:0]         asev_reg;
    logic signed [31:0] alev_reg;
    logic               filt_reg;
    // Divider
    logic [NUMW-1:0]    dq_reg;
    logic [DENW:0]      drem_reg;
    logic [CW-1:0]      dcnt_reg;
    // Multiply: two phases
    logic               mph_reg;
    logic signed [63:0] acc_reg;
    // Result
    logic [2:0]         stat_reg, range_reg;
    logic [1:0]         sev_reg;
    logic               taken_reg;

    logic signed [32:0] hh, hi, lo, ll, v, hy;
    logic [1:0] s_hh, s_hi, s_lo, s_ll;
    logic [2:0] c_range;
    logic [1:0] c_sev;
    logic signed [31:0] c_lev;
    logic [DENW-1:0] den;
    logic [DENW:0] rem_sh;
    logic signed [33:0] mul_a, mul_b;
    logic signed [63:0] prod;
    logic signed [63:0] lvl_full;
    logic signed [31:0] lvl_new;
    logic signed [31:0] lvl_neg;
    logic signed [31:0] fl_abs;
    logic signed [31:0] fl;
    logic [2:0] f_range;
    logic [1:0] f_sev;
    logic signed [31:0] f_lev;
    logic [2:0] stat_next_w, range_next_w;
    logic [1:0] sev_next_w;
    logic       taken_next_w;

    assign hh = 33'(limit_hihi);
    assign hi = 33'(limit_high);
    assign lo = 33'(limit_low);
    assign ll = 33'(limit_lolo);
    assign v  = 33'(val_reg);
    assign hy = 33'(signed'({2'b00, hysteresis}));
    assign s_hh = limit_severities[7:6];
    assign s_hi = limit_severities[5:4];
    assign s_lo = limit_severities[3:2];
    assign s_ll = limit_severities[1:0];

    // Limit check in priority order
    always_comb
    begin
        priority if (s_hh != 2'd0 && (v >= hh ||
            (lalm_reg == limit_hihi && v >= hh - hy)))
        begin
            c_range = RNG_HIHI; c_sev = s_hh; c_lev = limit_hihi;
        end
        else if (s_ll != 2'd0 && (v <= ll ||
            (lalm_reg == limit_lolo && v <= ll + hy)))
        begin
            c_range = RNG_LOLO; c_sev = s_ll; c_lev = limit_lolo;
        end
        else if (s_hi != 2'd0 && (v >= hi ||
            (lalm_reg == limit_high && v >= hi - hy)))
        begin
            c_range = RNG_HIGH; c_sev = s_hi; c_lev = limit_high;
        end
        else if (s_lo != 2'd0 && (v <= lo ||
            (lalm_reg == limit_low && v <= lo + hy)))
        begin
            c_range = RNG_LOW; c_sev = s_lo; c_lev = limit_low;
        end
        else
        begin
            c_range = RNG_NORM; c_sev = 2'd0; c_lev = val_reg;
        end
    end

    assign sts.need_filter = !undef_reg && filter_time_ms != 24'd0 && flvl_reg != 32'sd0;
    // done flags the cycle of the last quotient bit
    assign sts.div_done = dcnt_reg == CW'(NUMW - 1);
    assign sts.mul_done = mph_reg;

    // Restoring divider, one quotient bit a cycle
    assign den = DENW'(elap_reg) + DENW'(filter_time_ms);
    assign rem_sh = {drem_reg[DENW-1:0], dq_reg[NUMW-1]};

    // Shared signed multiplier: alpha*L, then (+/-(one-alpha))*R*one
    always_comb
    begin
        if (!mph_reg)
        begin
            mul_a = 34'(signed'({1'b0, dq_reg[QW-1:0]}));
            mul_b = 34'(flvl_reg);
        end
        else
        begin
            mul_a = (flvl_reg > 32'sd0) ? ONE - 34'(signed'({1'b0, dq_reg[QW-1:0]}))
                                        : 34'(signed'({1'b0, dq_reg[QW-1:0]})) - ONE;
            mul_b = 34'(signed'({31'd0, crange_reg})) <<< FRAC;
        end
    end
    assign prod = 64'(mul_a) * 64'(mul_b);

    // Finish: floor shift, rounding hysteresis, range
    always_comb
    begin
        lvl_full = acc_reg >>> FRAC;
        lvl_new = lvl_full[31:0];
        lvl_neg = (lvl_new[FRAC-1:0] > THRESH) ? -lvl_new : lvl_new;
        fl = lvl_neg >>> FRAC;
        fl_abs = (fl < 32'sd0) ? -fl : fl;
        if (fl_abs < 32'sd1) f_range = RNG_LOLO;
        else if (fl_abs > 32'sd5) f_range = RNG_HIHI;
        else f_range = fl_abs[2:0];
        unique case (f_range)
            RNG_HIHI: begin f_sev = s_hh; f_lev = limit_hihi; end
            RNG_HIGH: begin f_sev = s_hi; f_lev = limit_high; end
            RNG_LOW:  begin f_sev = s_lo; f_lev = limit_low;  end
            RNG_LOLO: begin f_sev = s_ll; f_lev = limit_lolo; end
            default:  begin f_sev = 2'd0; f_lev = val_reg;    end
        endcase
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg <= sample;
            undef_reg <= undefined;
            elap_reg <= elapsed_ms;
            prior_reg <= prior_severity;
        end
        if (cmd.classify)
        begin
            crange_reg <= c_range;
            asev_reg <= c_sev;
            alev_reg <= c_lev;
            filt_reg <= sts.need_filter;
        end
        if (cmd.div_start)
        begin
            dq_reg <= NUMW'({filter_time_ms, {FRAC{1'b0}}});
            drem_reg <= '0;
            dcnt_reg <= '0;
            mph_reg <= 1'b0;
        end
        else if (cmd.div_step)
        begin
            if (rem_sh >= {1'b0, den})
            begin
                drem_reg <= rem_sh - {1'b0, den};
                dq_reg <= {dq_reg[NUMW-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= rem_sh;
                dq_reg <= {dq_reg[NUMW-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + CW'(1);
        end
        else if (cmd.mul_step)
        begin
            acc_reg <= mph_reg ? acc_reg + prod : prod;
            mph_reg <= 1'b1;
        end
    end

    // Final result and state update
    always_comb
    begin
        logic [2:0] rng;
        logic [1:0] sv;
        logic signed [31:0] lev;
        logic tk;
        lalm_next = lalm_reg;
        flvl_next = flvl_reg;
        rng = crange_reg;
        sv = asev_reg;
        lev = alev_reg;
        if (undef_reg)
        begin
            flvl_next = '0;
        end
        else if (filter_time_ms == 24'd0)
        begin
            flvl_next = '0;
        end
        else if (!filt_reg)
        begin
            flvl_next = 32'(signed'({1'b0, crange_reg})) <<< FRAC;
        end
        else
        begin
            flvl_next = lvl_neg;
            rng = f_range;
            sv = f_sev;
            lev = f_lev;
        end
        tk = sv > prior_reg;
        if (undef_reg)
        begin
            stat_next_w = STAT_UNDEF;
            tk = undefined_severity > prior_reg;
            sev_next_w = tk ? undefined_severity : prior_reg;
            rng = RNG_NORM;
        end
        else if (sv != 2'd0)
        begin
            unique case (rng)
                RNG_HIHI: stat_next_w = STAT_HIHI;
                RNG_HIGH: stat_next_w = STAT_HIGH;
                RNG_LOW:  stat_next_w = STAT_LOW;
                RNG_LOLO: stat_next_w = STAT_LOLO;
                default:  stat_next_w = STAT_NONE;
            endcase
            sev_next_w = tk ? sv : prior_reg;
            if (tk) lalm_next = lev;
        end
        else
        begin
            stat_next_w = STAT_NONE;
            tk = 1'b0;
            sev_next_w = prior_reg;
            lalm_next = val_reg;
        end
        taken_next_w = tk;
        range_next_w = rng;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            stat_reg <= stat_next_w;
            sev_reg <= sev_next_w;
            taken_reg <= taken_next_w;
            range_reg <= range_next_w;
        end
    end

    // Block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lalm_reg <= '0;
            flvl_reg <= '0;
        end
        else if (cmd.finish)
        begin
            lalm_reg <= lalm_next;
            flvl_reg <= flvl_next;
        end
    end

    assign alarm_status = stat_reg;
    assign alarm_severity = sev_reg;
    assign status_taken = taken_reg;
    assign filtered_range = range_reg;

    a_taken_sev: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.finish) |-> (taken_reg == (sev_reg != prior_reg) || !taken_reg))
        else $error("taken flag inconsistent");
    a_undef_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && undef_reg |=> flvl_reg == 32'sd0)
        else $error("filter not cleared on undefined");
    a_range_ok: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.finish) |-> range_reg >= RNG_LOLO && range_reg <= RNG_HIHI)
        else $error("range out of bounds");
endmodule
`default_nettype wire

// ----- src/alarm_level_hysteresis_filter.sv -----
`default_nettype none
// Alarm limit check with hysteresis and optional exponential range filter.
// One request at a time. When the filter is off or idle, or the sample is
// undefined, a request passes limit check, finish, output and back to idle;
// with the filter running, a bit-serial alpha divider and a two-phase shared
// multiplier come between limit check and finish. A stalled output adds its
// wait. The user must write registers over the APB port only while no
// request is in flight; the block itself does not enforce this.
module alarm_level_hysteresis_filter
#(
    parameter int FILTER_FRAC_BITS = 24
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] sample,
    input  wire logic               undefined,
    input  wire logic [31:0]        elapsed_ms,
    input  wire logic [1:0]         prior_severity,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [2:0]              alarm_status,
    output logic [1:0]              alarm_severity,
    output logic                    status_taken,
    output logic [2:0]              filtered_range
);
    import alhf_pkg::*;

    logic [31:0] hihi_reg, high_reg, low_reg, lolo_reg;
    logic [30:0] hyst_reg;
    logic [7:0]  sevr_reg;
    logic [23:0] ftim_reg;
    logic [1:0]  usev_reg;
    cmd_t cmd;
    sts_t sts;
    logic [2:0] ridx;

    assign pready = 1'b1;
    assign ridx = paddr[4:2];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hihi_reg <= '0; high_reg <= '0; low_reg <= '0; lolo_reg <= '0;
            hyst_reg <= '0; sevr_reg <= '0; ftim_reg <= '0; usev_reg <= 2'd3;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (ridx)
                REG_HIHI: hihi_reg <= pwdata;
                REG_HIGH: high_reg <= pwdata;
                REG_LOW:  low_reg  <= pwdata;
                REG_LOLO: lolo_reg <= pwdata;
                REG_HYST: hyst_reg <= pwdata[30:0];
                REG_SEVR: sevr_reg <= pwdata[7:0];
                REG_FTIM: ftim_reg <= pwdata[23:0];
                REG_USEV: usev_reg <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        unique case (ridx)
            REG_HIHI: prdata = hihi_reg;
            REG_HIGH: prdata = high_reg;
            REG_LOW:  prdata = low_reg;
            REG_LOLO: prdata = lolo_reg;
            REG_HYST: prdata = {1'b0, hyst_reg};
            REG_SEVR: prdata = {24'd0, sevr_reg};
            REG_FTIM: prdata = {8'd0, ftim_reg};
            REG_USEV: prdata = {30'd0, usev_reg};
            default:  prdata = '0;
        endcase
    end

    alhf_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .cmd(cmd), .sts(sts)
    );

    alhf_dp #(.FRAC(FILTER_FRAC_BITS)) u_dp
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .sample(sample), .undefined(undefined), .elapsed_ms(elapsed_ms),
        .prior_severity(prior_severity),
        .limit_hihi(hihi_reg), .limit_high(high_reg),
        .limit_low(low_reg), .limit_lolo(lolo_reg),
        .hysteresis(hyst_reg), .limit_severities(sevr_reg),
        .filter_time_ms(ftim_reg), .undefined_severity(usev_reg),
        .alarm_status(alarm_status), .alarm_severity(alarm_severity),
        .status_taken(status_taken), .filtered_range(filtered_range)
    );
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import alhf_pkg::*;

    localparam int FRAC = 24;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [2:0] status;
        logic [1:0] sev;
        logic       taken;
        logic [2:0] rng;
    } alarm_t;

    typedef struct {
        logic signed [31:0] sample;
        logic               undef;
        logic [31:0]        elapsed;
        logic [1:0]         prior;
        bit                 typed;
        alarm_t             want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] sample = '0;
    logic undefined = 1'b0;
    logic [31:0] elapsed_ms = '0;
    logic [1:0] prior_severity = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] alarm_status;
    logic [1:0] alarm_severity;
    logic status_taken;
    logic [2:0] filtered_range;

    // register mirror and predictor state
    logic signed [31:0] lim_hihi, lim_high, lim_low, lim_lolo;
    logic [30:0] hyst_band;
    logic [7:0] lim_sevr;
    logic [23:0] filt_ms;
    logic [1:0] undef_sevr;
    logic signed [31:0] last_level;
    logic signed [31:0] filt_level;

    alarm_t pending_alarms[$];
    int errors = 0;
    bit calm = 0;
    bit hold_req = 0;
    bit in_fire, out_fire;

    alarm_level_hysteresis_filter #(.FILTER_FRAC_BITS(FRAC)) dut (.*);

    always #5 clk = ~clk;

    // alarm check with optional level filter, updates predictor state
    function automatic alarm_t classify_sample(logic signed [31:0] val, logic undef,
                                               logic [31:0] el, logic [1:0] prior);
        longint v, lalm, hh, hi, lo, ll, hy, lvl, a, rt, num, fl, alev, one, thresh;
        logic [63:0] dividend, divisor;
        logic [1:0] s_hh, s_hi, s_lo, s_ll, asev;
        logic [2:0] rng;
        alarm_t r;
        one = longint'(1) << FRAC;
        thresh = ((longint'(6321) << FRAC) + 5000) / 10000;
        v = val;
        lalm = last_level;
        hh = lim_hihi; hi = lim_high; lo = lim_low; ll = lim_lolo;
        hy = longint'(hyst_band);
        s_hh = lim_sevr[7:6]; s_hi = lim_sevr[5:4];
        s_lo = lim_sevr[3:2]; s_ll = lim_sevr[1:0];
        if (undef) begin
            filt_level = '0;
            r.status = STAT_UNDEF;
            r.taken = undef_sevr > prior;
            r.sev = r.taken ? undef_sevr : prior;
            r.rng = RNG_NORM;
            return r;
        end
        if (s_hh != 0 && (v >= hh || (lalm == hh && v >= hh - hy))) begin
            asev = s_hh; alev = hh; rng = RNG_HIHI;
        end else if (s_ll != 0 && (v <= ll || (lalm == ll && v <= ll + hy))) begin
            asev = s_ll; alev = ll; rng = RNG_LOLO;
        end else if (s_hi != 0 && (v >= hi || (lalm == hi && v >= hi - hy))) begin
            asev = s_hi; alev = hi; rng = RNG_HIGH;
        end else if (s_lo != 0 && (v <= lo || (lalm == lo && v <= lo + hy))) begin
            asev = s_lo; alev = lo; rng = RNG_LOW;
        end else begin
            asev = 0; alev = v; rng = RNG_NORM;
        end
        if (filt_ms != 0) begin
            lvl = filt_level;
            if (lvl == 0) begin
                lvl = longint'(rng) * one;
            end else begin
                dividend = 64'(filt_ms) << FRAC;
                divisor = 64'(el) + 64'(filt_ms);
                a = longint'(dividend / divisor);
                rt = longint'(rng) * one;
                num = a * lvl + ((lvl > 0) ? (one - a) : (a - one)) * rt;
                lvl = num >>> FRAC;
                if ((lvl & (one - 1)) > thresh)
                    lvl = -lvl;
                fl = lvl >>> FRAC;
                if (fl < 0) fl = -fl;
                if (fl < 1) fl = 1;
                if (fl > 5) fl = 5;
                rng = 3'(fl);
                case (rng)
                    RNG_HIHI: begin asev = s_hh; alev = hh; end
                    RNG_HIGH: begin asev = s_hi; alev = hi; end
                    RNG_LOW:  begin asev = s_lo; alev = lo; end
                    RNG_LOLO: begin asev = s_ll; alev = ll; end
                    default:  asev = 0;
                endcase
            end
            filt_level = lvl[31:0];
        end else begin
            filt_level = '0;
        end
        r.rng = rng;
        if (asev != 0) begin
            case (rng)
                RNG_HIHI: r.status = STAT_HIHI;
                RNG_HIGH: r.status = STAT_HIGH;
                RNG_LOW:  r.status = STAT_LOW;
                default:  r.status = STAT_LOLO;
            endcase
            r.taken = asev > prior;
            if (r.taken)
                last_level = alev[31:0];
        end else begin
            r.status = STAT_NONE;
            r.taken = 1'b0;
            last_level = val;
        end
        r.sev = r.taken ? asev : prior;
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // register write: setup cycle, then access cycle
    task automatic reg_write(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = {idx, 2'b00}; pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_HIHI: lim_hihi = data;
            REG_HIGH: lim_high = data;
            REG_LOW:  lim_low = data;
            REG_LOLO: lim_lolo = data;
            REG_HYST: hyst_band = data[30:0];
            REG_SEVR: lim_sevr = data[7:0];
            REG_FTIM: filt_ms = data[23:0];
            default:  undef_sevr = data[1:0];
        endcase
    endtask

    task automatic write_all(logic [31:0] hh, logic [31:0] hi, logic [31:0] lo,
                             logic [31:0] ll, logic [31:0] hy, logic [31:0] sv,
                             logic [31:0] ft, logic [31:0] us);
        reg_write(REG_HIHI, hh);
        reg_write(REG_HIGH, hi);
        reg_write(REG_LOW, lo);
        reg_write(REG_LOLO, ll);
        reg_write(REG_HYST, hy);
        reg_write(REG_SEVR, sv);
        reg_write(REG_FTIM, ft);
        reg_write(REG_USEV, us);
    endtask

    // offer one request, predict at acceptance; called at a falling edge
    task automatic send_request(row_t rq);
        alarm_t exp_alarm;
        if (!calm && $urandom_range(99) < 20) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid = 1'b1;
        sample = rq.sample;
        undefined = rq.undef;
        elapsed_ms = rq.elapsed;
        prior_severity = rq.prior;
        do @(posedge clk); while (!in_ready);
        exp_alarm = classify_sample(rq.sample, rq.undef, rq.elapsed, rq.prior);
        pending_alarms.push_back(rq.typed ? rq.want : exp_alarm);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_alarms.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic row_t mk(logic [31:0] s, logic u, logic [31:0] e, logic [1:0] p);
        row_t r;
        r.sample = s; r.undef = u; r.elapsed = e; r.prior = p;
        r.typed = 0; r.want = '0;
        return r;
    endfunction

    function automatic row_t mk_typed(logic [31:0] s, logic u, logic [1:0] p, alarm_t w);
        row_t r;
        r = mk(s, u, 32'd0, p);
        r.typed = 1; r.want = w;
        return r;
    endfunction

    // random request, mostly aimed near the configured limits
    function automatic row_t random_request();
        logic signed [31:0] base, offs;
        int pick;
        pick = $urandom_range(3);
        base = (pick == 0) ? lim_hihi : (pick == 1) ? lim_high :
               (pick == 2) ? lim_low : lim_lolo;
        offs = $urandom_range(0, 20 << 16);
        offs = offs - (10 << 16);
        return mk(($urandom_range(99) < 70) ? base + offs : $urandom,
                  $urandom_range(99) < 5,
                  ($urandom_range(99) < 80) ? $urandom_range(0, 2000) : $urandom,
                  2'($urandom_range(3)));
    endfunction

    // response checker
    always @(posedge clk) begin
        alarm_t want;
        in_fire = in_valid && in_ready;
        out_fire = out_valid && out_ready;
        if (rst_n && out_fire) begin
            if (pending_alarms.size() == 0) begin
                report("unexpected result", alarm_status, -1);
            end else begin
                want = pending_alarms.pop_front();
                if (alarm_status !== want.status)
                    report("alarm_status", alarm_status, want.status);
                if (alarm_severity !== want.sev)
                    report("alarm_severity", alarm_severity, want.sev);
                if (status_taken !== want.taken)
                    report("status_taken", status_taken, want.taken);
                if (filtered_range !== want.rng)
                    report("filtered_range", filtered_range, want.rng);
            end
        end
    end

    // receiver: random stalls, a long hold-off on request
    initial begin
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 0;
            end
            out_ready = calm || ($urandom_range(99) >= 20);
        end
    end

    // watchdog on cycles without progress
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            quiet = (in_fire || out_fire || psel) ? 0 : quiet + 1;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        row_t rows[$];
        alarm_t quiet_norm, undef_hit;
        logic signed [31:0] mid, step;
        lim_hihi = 0; lim_high = 0; lim_low = 0; lim_lolo = 0;
        hyst_band = 0; lim_sevr = 0; filt_ms = 0; undef_sevr = 2'd3;
        last_level = 0; filt_level = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // after reset: all limits off, filter off
        quiet_norm = '{status: STAT_NONE, sev: 2'd2, taken: 1'b0, rng: RNG_NORM};
        undef_hit = '{status: STAT_UNDEF, sev: 2'd3, taken: 1'b1, rng: RNG_NORM};
        rows.push_back(mk_typed(32'h7FFF_FFFF, 1'b0, 2'd2, quiet_norm));
        rows.push_back(mk_typed(32'h8000_0000, 1'b0, 2'd2, quiet_norm));
        rows.push_back(mk_typed(32'd0, 1'b1, 2'd0, undef_hit));
        undef_hit.sev = 2'd3; undef_hit.taken = 1'b0;
        rows.push_back(mk_typed(32'd5, 1'b1, 2'd3, undef_hit));
        foreach (rows[i]) send_request(rows[i]);
        rows.delete();

        // every limit, hysteresis hold, severity not raised
        wait_idle();
        write_all(100 << 16, 50 << 16, -(50 << 16), -(100 << 16), 5 << 16,
                  32'b1110_0110, 0, 1);
        rows.push_back(mk(32'h7FFF_FFFF, 1'b0, 32'd0, 2'd0));
        rows.push_back(mk(98 << 16, 1'b0, 32'd0, 2'd0));
        rows.push_back(mk(94 << 16, 1'b0, 32'd0, 2'd0));
        rows.push_back(mk(60 << 16, 1'b0, 32'd0, 2'd3));
        rows.push_back(mk(32'h8000_0000, 1'b0, 32'd0, 2'd0));
        rows.push_back(mk(-(97 << 16), 1'b0, 32'd0, 2'd1));
        rows.push_back(mk(-(60 << 16), 1'b0, 32'd0, 2'd0));
        rows.push_back(mk(32'd0, 1'b0, 32'd0, 2'd0));
        rows.push_back(mk(32'd0, 1'b1, 32'hFFFF_FFFF, 2'd0));
        foreach (rows[i]) send_request(rows[i]);
        rows.delete();

        // filter: idle load, smoothing, clear by undefined value
        wait_idle();
        reg_write(REG_FTIM, 1000);
        rows.push_back(mk(120 << 16, 1'b0, 32'd100, 2'd0));
        rows.push_back(mk(32'd0, 1'b0, 32'd100, 2'd0));
        rows.push_back(mk(32'd0, 1'b0, 32'd0, 2'd0));
        rows.push_back(mk(-(120 << 16), 1'b0, 32'hFFFF_FFFF, 2'd0));
        rows.push_back(mk(70 << 16, 1'b0, 32'd500, 2'd2));
        rows.push_back(mk(32'd0, 1'b1, 32'd10, 2'd0));
        rows.push_back(mk(-(70 << 16), 1'b0, 32'd10, 2'd0));
        rows.push_back(mk(-(70 << 16), 1'b0, 32'd3000, 2'd0));
        foreach (rows[i]) send_request(rows[i]);
        rows.delete();

        // random phases over several settings
        for (int phase = 0; phase < 7; phase++) begin
            wait_idle();
            mid = $urandom_range(0, 400 << 16); mid = mid - (200 << 16);
            step = $urandom_range(1 << 16, 60 << 16);
            case (phase)
                1: write_all(32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h8000_0001,
                             32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_00FF, 0, 0);
                3: write_all(mid + 2 * step, mid + step, mid - step, mid - 2 * step,
                             $urandom_range(0, 8 << 16), $urandom_range(255),
                             32'h00FF_FFFF, 2);
                4: write_all(mid + 2 * step, mid + step, mid - step, mid - 2 * step,
                             $urandom_range(0, 8 << 16), 32'h0000_00FF, 1, 3);
                5: write_all(mid + 2 * step, mid + step, mid - step, mid - 2 * step,
                             3 << 16, 32'h0000_0000, $urandom_range(1, 5000), 1);
                6: write_all($urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom);
                default: write_all(mid + 2 * step, mid + step, mid - step, mid - 2 * step,
                                   $urandom_range(0, 8 << 16), $urandom_range(255),
                                   (phase == 2) ? $urandom_range(1, 5000) : 0,
                                   $urandom_range(3));
            endcase
            calm = (phase == 4);
            hold_req = (phase == 2);
            repeat (95) send_request(random_request());
        end

        // drain
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_alarms.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
